// ===== sv/msab_pkg.sv =====
// Shared types and constants of the masked sprite alpha blend block.
// Used by the register file, the mask and blend pipelines and the top level.
`default_nettype none

package msab_pkg;

  localparam int unsigned CfgAddrW = 5;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned SpriteDimDefault = 256;

  typedef struct packed {
    logic [7:0] blend_weight;
    logic       clip_enable;
    logic       wide_mode;
    logic [9:0] origin_x;
    logic [9:0] origin_y;
  } cfg_t;

endpackage

`default_nettype wire

// ===== sv/msab_regs.sv =====
// Configuration register file behind an APB-style port.
// Depends on msab_pkg for the register struct and port widths.
`default_nettype none

module msab_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [msab_pkg::CfgAddrW-1:0] paddr,
  input  wire logic [msab_pkg::CfgDataW-1:0] pwdata,
  output logic      [msab_pkg::CfgDataW-1:0] prdata,
  output logic                               pready,
  output msab_pkg::cfg_t                     cfg_o
);
  import msab_pkg::*;

  localparam logic [2:0] RegBlendWeight = 3'd0;
  localparam logic [2:0] RegClipEnable  = 3'd1;
  localparam logic [2:0] RegWideMode    = 3'd2;
  localparam logic [2:0] RegOriginX     = 3'd3;
  localparam logic [2:0] RegOriginY     = 3'd4;

  cfg_t       cfg_q, cfg_d;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        RegBlendWeight: cfg_d.blend_weight = pwdata[7:0];
        RegClipEnable:  cfg_d.clip_enable  = pwdata[0];
        RegWideMode:    cfg_d.wide_mode    = pwdata[0];
        RegOriginX:     cfg_d.origin_x     = pwdata[9:0];
        RegOriginY:     cfg_d.origin_y     = pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegBlendWeight: prdata = {24'd0, cfg_q.blend_weight};
      RegClipEnable:  prdata = {31'd0, cfg_q.clip_enable};
      RegWideMode:    prdata = {31'd0, cfg_q.wide_mode};
      RegOriginX:     prdata = {22'd0, cfg_q.origin_x};
      RegOriginY:     prdata = {22'd0, cfg_q.origin_y};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/msab_mask.sv =====
// Three-stage write decision: screen point, logo mask line pieces, final test.
// Depends on msab_pkg for the configuration struct.
`default_nettype none

module msab_mask #(
  parameter int unsigned SpriteDim = msab_pkg::SpriteDimDefault
) (
  input  wire logic           clk_i,
  input  wire logic           en_i,
  input  msab_pkg::cfg_t      cfg_i,
  input  wire logic [7:0]     col_i,
  input  wire logic [7:0]     row_i,
  input  wire logic           spr_nz_i,
  output logic                write_o
);
  import msab_pkg::*;

  localparam logic [10:0] DimLimit    = 11'(SpriteDim);
  localparam logic [20:0] Recip1000   = 21'd1073742;
  localparam logic signed [14:0] Edge4 = 15'sd1368;

  function automatic logic signed [14:0] quad(input logic signed [11:0] l);
    return {l[11], l, 2'b00};
  endfunction

  // Stage 1: screen point.
  logic [10:0]        x_sum, y_sum;
  logic [12:0]        xq_d;
  logic signed [11:0] y_d;
  logic               base_d;
  logic [12:0]        s1_xq_q;
  logic signed [11:0] s1_y_q;
  logic               s1_base_q;

  always_comb begin
    x_sum  = {3'd0, col_i} + {1'b0, cfg_i.origin_x};
    y_sum  = {3'd0, row_i} + {1'b0, cfg_i.origin_y};
    y_d    = $signed({1'b0, y_sum}) - 12'sd5;
    if (cfg_i.wide_mode) begin
      xq_d = {2'd0, x_sum} + {1'b0, x_sum, 1'b0} + 13'd320;
    end else begin
      xq_d = {x_sum, 2'b00};
    end
    base_d = spr_nz_i && ({3'd0, col_i} < DimLimit) && ({3'd0, row_i} < DimLimit);
  end

  // Stage 2: magnitudes of the line pieces times their slopes.
  logic signed [11:0] t1, v3;
  logic [11:0]        a1, a3;
  logic [10:0]        u2;
  logic [13:0]        p1_d;
  logic [19:0]        p2_d, p3_d;
  logic [13:0]        s2_p1_q;
  logic [19:0]        s2_p2_q, s2_p3_q;
  logic               s2_pos1_q, s2_neg3_q, s2_lo_q, s2_mid_q, s2_base_q;
  logic [12:0]        s2_xq_q;

  always_comb begin
    t1 = s1_y_q - 12'sd100;
    v3 = s1_y_q - 12'sd243;
    a1 = t1[11] ? (~t1 + 12'd1) : t1;
    a3 = v3[11] ? (~v3 + 12'd1) : v3;
    if (s1_y_q >= 12'sd215) begin
      u2 = 11'(s1_y_q - 12'sd215);
    end else begin
      u2 = '0;
    end
    p1_d = 14'(a1[10:0]) * 14'd5;
    p2_d = 20'(u2) * 20'd793;
    p3_d = 20'(a3[10:0]) * 20'd821;
  end

  // Stage 3: truncated quotients by one thousand.
  logic [40:0] prod2, prod3;
  logic [9:0]  s3_q1_q, s3_q2_q, s3_q3_q;
  logic        s3_pos1_q, s3_neg3_q, s3_lo_q, s3_mid_q, s3_base_q;
  logic [12:0] s3_xq_q;

  assign prod2 = 41'(s2_p2_q) * 41'(Recip1000);
  assign prod3 = 41'(s2_p3_q) * 41'(Recip1000);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_xq_q   <= xq_d;
      s1_y_q    <= y_d;
      s1_base_q <= base_d;

      s2_p1_q   <= p1_d;
      s2_p2_q   <= p2_d;
      s2_p3_q   <= p3_d;
      s2_pos1_q <= !t1[11];
      s2_neg3_q <= v3[11];
      s2_lo_q   <= s1_y_q < 12'sd188;
      s2_mid_q  <= s1_y_q < 12'sd215;
      s2_base_q <= s1_base_q;
      s2_xq_q   <= s1_xq_q;

      s3_q1_q   <= s2_p1_q[12:3];
      s3_q2_q   <= prod2[39:30];
      s3_q3_q   <= prod3[39:30];
      s3_pos1_q <= s2_pos1_q;
      s3_neg3_q <= s2_neg3_q;
      s3_lo_q   <= s2_lo_q;
      s3_mid_q  <= s2_mid_q;
      s3_base_q <= s2_base_q;
      s3_xq_q   <= s2_xq_q;
    end
  end

  // Line values and the mask test.
  logic signed [11:0] l1, l2, l3;
  logic signed [14:0] xqs;
  logic               in_mask;

  always_comb begin
    l1  = s3_pos1_q ? 12'sd397 - $signed({2'b00, s3_q1_q})
                    : 12'sd397 + $signed({2'b00, s3_q1_q});
    l2  = 12'sd319 - $signed({2'b00, s3_q2_q});
    l3  = s3_neg3_q ? 12'sd342 - $signed({2'b00, s3_q3_q})
                    : 12'sd342 + $signed({2'b00, s3_q3_q});
    xqs = $signed({2'b00, s3_xq_q});
    if (s3_lo_q) begin
      in_mask = xqs < quad(l1);
    end else if (s3_mid_q) begin
      in_mask = xqs < Edge4;
    end else if (xqs < quad(l2)) begin
      in_mask = 1'b1;
    end else if (xqs < quad(l3)) begin
      in_mask = 1'b0;
    end else begin
      in_mask = xqs < Edge4;
    end
    write_o = s3_base_q && (!cfg_i.clip_enable || in_mask);
  end

endmodule

`default_nettype wire

// ===== sv/msab_blend.sv =====
// Three-stage weighted blend of sprite and framebuffer bytes, red and blue swapped.
// Depends on msab_pkg for the configuration struct.
`default_nettype none

module msab_blend (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  msab_pkg::cfg_t   cfg_i,
  input  wire logic [23:0] spr_rgb_i,
  input  wire logic [23:0] fb_i,
  output logic      [23:0] mix_o,
  output logic      [23:0] fb_o
);
  import msab_pkg::*;

  localparam logic [16:0] Recip255 = 17'd65794;

  logic [2:0][7:0]  s1_spr_q, s1_fb_q;
  logic [2:0][15:0] s2_ms_q, s2_mf_q, ms_d, mf_d;
  logic [2:0][7:0]  s3_mix_q, mix_d;
  logic [23:0]      s2_fb_q, s3_fb_q;
  logic [7:0]       w_inv;
  logic [32:0]      qs [3];
  logic [32:0]      qf [3];

  assign w_inv = 8'd255 - cfg_i.blend_weight;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ms_d[i]  = 16'(s1_spr_q[i]) * 16'(cfg_i.blend_weight);
      mf_d[i]  = 16'(s1_fb_q[i]) * 16'(w_inv);
      qs[i]    = 33'(s2_ms_q[i]) * 33'(Recip255);
      qf[i]    = 33'(s2_mf_q[i]) * 33'(Recip255);
      mix_d[i] = qs[i][31:24] + qf[i][31:24];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_spr_q <= {spr_rgb_i[7:0], spr_rgb_i[15:8], spr_rgb_i[23:16]};
      s1_fb_q  <= fb_i;
      s2_ms_q  <= ms_d;
      s2_mf_q  <= mf_d;
      s2_fb_q  <= s1_fb_q;
      s3_mix_q <= mix_d;
      s3_fb_q  <= s2_fb_q;
    end
  end

  assign mix_o = s3_mix_q;
  assign fb_o  = s3_fb_q;

endmodule

`default_nettype wire

// ===== sv/masked_sprite_alpha_blend_top.sv =====
// Top level of the masked sprite alpha blend block: stream ports, output stage.
// Depends on msab_pkg, msab_regs, msab_mask and msab_blend.
`default_nettype none

// One pixel transaction is accepted per clock and its result appears in the output
// register behind the three compute stages; that pipeline plus the
// output register moves as one, so a stalled output holds every stage in place and
// throughput is one pixel per cycle whenever the result side takes data.
// The user must write configuration registers through the APB port while no pixel
// is in flight; the block does not enforce it. A pixel is written when its sprite
// word is nonzero, it lies inside the sprite and, with clipping on, its screen point
// lies inside the logo mask; an unwritten pixel returns its framebuffer bytes.
module masked_sprite_alpha_blend_top #(
  parameter int unsigned SpriteDim = msab_pkg::SpriteDimDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // tdata: sprite_col[7:0], sprite_row[15:8], sprite_pixel[47:16], screen_pixel[71:48]
  input  wire logic [71:0]                   s_axis_tdata,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: blended_pixel[23:0]
  output logic      [23:0]                   m_axis_tdata,
  // tuser: write_enable[0]
  output logic      [0:0]                    m_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [msab_pkg::CfgAddrW-1:0] paddr,
  input  wire logic [msab_pkg::CfgDataW-1:0] pwdata,
  output logic      [msab_pkg::CfgDataW-1:0] prdata,
  output logic                               pready
);
  import msab_pkg::*;

  cfg_t        cfg;
  logic        adv;
  logic [3:0]  vld_q;
  logic        mask_we;
  logic [23:0] mix, fb3;
  logic        out_we_q;
  logic [23:0] out_pix_q;

  assign adv           = !vld_q[3] || m_axis_tready;
  assign s_axis_tready = adv;

  msab_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  msab_mask #(
    .SpriteDim (SpriteDim)
  ) u_mask (
    .clk_i    (clk_i),
    .en_i     (adv),
    .cfg_i    (cfg),
    .col_i    (s_axis_tdata[7:0]),
    .row_i    (s_axis_tdata[15:8]),
    .spr_nz_i (|s_axis_tdata[47:16]),
    .write_o  (mask_we)
  );

  msab_blend u_blend (
    .clk_i     (clk_i),
    .en_i      (adv),
    .cfg_i     (cfg),
    .spr_rgb_i (s_axis_tdata[39:16]),
    .fb_i      (s_axis_tdata[71:48]),
    .mix_o     (mix),
    .fb_o      (fb3)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_we_q  <= mask_we;
      out_pix_q <= mask_we ? mix : fb3;
    end
  end

  assign m_axis_tvalid   = vld_q[3];
  assign m_axis_tdata    = out_pix_q;
  assign m_axis_tuser[0] = out_we_q;

  a_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && vld_q[2]) |=> m_axis_tvalid)
    else $error("stage three transaction did not reach the output");

  a_bubble : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !vld_q[2]) |=> !m_axis_tvalid)
    else $error("output valid without a transaction behind it");

  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("pipeline valid bits moved during a stall");

  a_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> vld_q[0])
    else $error("accepted transaction missing from stage one");

endmodule

`default_nettype wire

// ===== test/masked_sprite_alpha_blend_top_tb.sv =====
// Self-checking testbench for masked_sprite_alpha_blend_top: pixel streams with random idling
// on both sides, results checked against an in-bench blend and logo mask predictor.
// Depends on msab_pkg and the masked_sprite_alpha_blend_top RTL.
module masked_sprite_alpha_blend_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import msab_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int SettleCycles = 8;
  localparam int ReportLimit = 10;

  typedef enum int {
    RegBlendWeight = 0,
    RegClipEnable  = 1,
    RegWideMode    = 2,
    RegOriginX     = 3,
    RegOriginY     = 4,
    RegUnmapped    = 5
  } reg_index_e;

  typedef struct {
    logic [7:0]  col;
    logic [7:0]  row;
    logic [31:0] sprite;
    logic [23:0] screen;
  } pixel_in_t;

  typedef struct {
    logic        write_en;
    logic [23:0] pixel;
  } blend_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic [71:0]         s_axis_tdata = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [23:0]         m_axis_tdata;
  logic [0:0]          m_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [CfgDataW-1:0] pwdata = '0;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  cfg_t          shadow_cfg = '0;
  blend_result_t expected_pixels[$];
  bit            gaps_on = 1'b1;
  bit            stalls_on = 1'b1;
  int            stall_left = 0;
  int            mismatch_count = 0;
  int            sent_count = 0;
  int            written_count = 0;
  int            settings_count = 0;
  int            cycle_count = 0;

  masked_sprite_alpha_blend_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk_i = ~clk_i;

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int line_point(int y, int a, int m, int b);
    return ((y - a) * m) / 1000 + b;
  endfunction

  function automatic bit inside_logo(int x, int y);
    int xq;
    int edge_q;
    xq = shadow_cfg.wide_mode ? (3 * (x - 320) + 1280) : (4 * x);
    edge_q = 4 * 342;
    y = y - 5;
    if (y < 188) return xq < 4 * line_point(y, 100, -625, 397);
    if (y < 215) return xq < edge_q;
    if (xq < 4 * line_point(y, 215, -793, 319)) return 1'b1;
    if (xq < 4 * line_point(y, 243, 821, 342)) return 1'b0;
    return xq < edge_q;
  endfunction

  function automatic logic [7:0] mix_channel(int unsigned s, int unsigned f, int unsigned w);
    return 8'((s * w) / 255 + (f * (255 - w)) / 255);
  endfunction

  function automatic blend_result_t predict_blend(pixel_in_t p);
    blend_result_t res;
    int unsigned   w;
    w = shadow_cfg.blend_weight;
    res.write_en = (p.sprite != 0) && (int'(p.col) < 256) && (int'(p.row) < 256);
    if (res.write_en && shadow_cfg.clip_enable)
      res.write_en = inside_logo(int'(shadow_cfg.origin_x) + int'(p.col),
                                 int'(shadow_cfg.origin_y) + int'(p.row));
    res.pixel = p.screen;
    if (res.write_en)
      res.pixel = {mix_channel(p.sprite[7:0], p.screen[23:16], w),
                   mix_channel(p.sprite[15:8], p.screen[15:8], w),
                   mix_channel(p.sprite[23:16], p.screen[7:0], w)};
    return res;
  endfunction

  function automatic logic [31:0] shadow_value(reg_index_e idx);
    case (idx)
      RegBlendWeight: return {24'h0, shadow_cfg.blend_weight};
      RegClipEnable:  return {31'h0, shadow_cfg.clip_enable};
      RegWideMode:    return {31'h0, shadow_cfg.wide_mode};
      RegOriginX:     return {22'h0, shadow_cfg.origin_x};
      RegOriginY:     return {22'h0, shadow_cfg.origin_y};
      default:        return '0;
    endcase
  endfunction

  function automatic pixel_in_t random_pixel();
    pixel_in_t p;
    int        r;
    r = $urandom_range(0, 99);
    p.col = 8'($urandom_range(0, 255));
    p.row = 8'($urandom_range(0, 255));
    p.screen = 24'($urandom());
    if (r < 10) p.sprite = '0;
    else if (r < 20) p.sprite = {8'($urandom_range(1, 255)), 24'h0};
    else p.sprite = $urandom();
    return p;
  endfunction

  // Result side: random stalls and in-order comparison against the expected pixels.
  always @(posedge clk_i) begin
    blend_result_t exp_res;
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_pixels.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= ReportLimit)
          $display("Unexpected result transaction: tdata %h tuser %b", m_axis_tdata,
                   m_axis_tuser);
      end else begin
        exp_res = expected_pixels.pop_front();
        if (exp_res.write_en) written_count++;
        if (m_axis_tuser[0] !== exp_res.write_en || m_axis_tdata !== exp_res.pixel) begin
          mismatch_count++;
          if (mismatch_count <= ReportLimit)
            $display("Result mismatch: write_enable %b/%b blended_pixel %h/%h (exp/act)",
                     exp_res.write_en, m_axis_tuser[0], exp_res.pixel, m_axis_tdata);
        end
      end
    end
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stalls_on && $urandom_range(0, 99) < 25) begin
      m_axis_tready <= 1'b0;
      stall_left <= pick_idle();
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_pixel(input pixel_in_t p);
    int gap;
    gap = gaps_on ? pick_idle() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata <= {p.screen, p.sprite, p.row, p.col};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_pixels.push_back(predict_blend(p));
    sent_count++;
  endtask

  task automatic send_at(input int col, input int row, input logic [31:0] sprite);
    pixel_in_t p;
    p.col = 8'(col);
    p.row = 8'(row);
    p.sprite = sprite;
    p.screen = 24'($urandom());
    send_pixel(p);
  endtask

  task automatic wait_results_done();
    s_axis_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apb_access(input bit is_write, input reg_index_e idx,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= is_write;
    paddr <= CfgAddrW'(int'(idx) * 4);
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_reg(input reg_index_e idx, input logic [31:0] value);
    logic [31:0] unused;
    apb_access(1'b1, idx, value, unused);
    case (idx)
      RegBlendWeight: shadow_cfg.blend_weight = value[7:0];
      RegClipEnable:  shadow_cfg.clip_enable = value[0];
      RegWideMode:    shadow_cfg.wide_mode = value[0];
      RegOriginX:     shadow_cfg.origin_x = value[9:0];
      RegOriginY:     shadow_cfg.origin_y = value[9:0];
      default:        ;
    endcase
  endtask

  task automatic check_reg(input reg_index_e idx);
    logic [31:0] rdata;
    apb_access(1'b0, idx, '0, rdata);
    if (rdata !== shadow_value(idx)) begin
      mismatch_count++;
      if (mismatch_count <= ReportLimit)
        $display("Register %s read %h, expected %h", idx.name(), rdata, shadow_value(idx));
    end
  endtask

  task automatic apply_setting(input logic [7:0] weight, input bit clip, input bit wide,
                               input logic [9:0] org_x, input logic [9:0] org_y);
    wait_results_done();
    write_reg(RegBlendWeight, {8'($urandom_range(0, 255)), 24'h0} | 32'(weight));
    write_reg(RegClipEnable, {31'($urandom()), clip});
    write_reg(RegWideMode, {31'($urandom()), wide});
    write_reg(RegOriginX, {22'($urandom()), org_x});
    write_reg(RegOriginY, {22'($urandom()), org_y});
    settings_count++;
  endtask

  task automatic test_register_access();
    reg_index_e idx;
    idx = idx.first();
    repeat (idx.num()) begin
      if (idx != RegUnmapped) check_reg(idx);
      idx = idx.next();
    end
    apply_setting(8'd255, 1'b1, 1'b1, 10'd1023, 10'd1023);
    write_reg(RegUnmapped, 32'hffff_ffff);
    idx = idx.first();
    repeat (idx.num()) begin
      if (idx != RegUnmapped) check_reg(idx);
      idx = idx.next();
    end
    apply_setting(8'd0, 1'b0, 1'b0, 10'd0, 10'd0);
    check_reg(RegOriginX);
  endtask

  task automatic test_field_extremes();
    pixel_in_t p;
    apply_setting(8'd255, 1'b0, 1'b0, 10'd0, 10'd0);
    p = '{col: 8'd0, row: 8'd0, sprite: 32'h0, screen: 24'hffffff};
    send_pixel(p);
    p = '{col: 8'd255, row: 8'd255, sprite: 32'hff00_0000, screen: 24'h123456};
    send_pixel(p);
    p = '{col: 8'd0, row: 8'd255, sprite: 32'hffff_ffff, screen: 24'h000000};
    send_pixel(p);
    p = '{col: 8'd255, row: 8'd0, sprite: 32'h00ff_0000, screen: 24'hffffff};
    send_pixel(p);
    apply_setting(8'd0, 1'b0, 1'b0, 10'd0, 10'd0);
    p = '{col: 8'd0, row: 8'd255, sprite: 32'h0000_ff00, screen: 24'ha5a5a5};
    send_pixel(p);
    apply_setting(8'd128, 1'b0, 1'b0, 10'd0, 10'd0);
    p = '{col: 8'd17, row: 8'd200, sprite: 32'h5a12_3456, screen: 24'h0fedcb};
    send_pixel(p);
  endtask

  task automatic test_logo_mask();
    apply_setting(8'($urandom()), 1'b1, 1'b0, 10'd200, 10'd0);
    // Lower band: inside, gap between the two lower lines, inside again, right edge.
    send_at(115, 225, $urandom() | 1);
    send_at(116, 225, $urandom() | 1);
    send_at(123, 225, $urandom() | 1);
    send_at(124, 225, $urandom() | 1);
    send_at(141, 225, $urandom() | 1);
    send_at(142, 225, $urandom() | 1);
    send_at(141, 205, $urandom() | 1);
    send_at(142, 205, $urandom() | 1);
    send_at(196, 105, $urandom() | 1);
    send_at(197, 105, $urandom() | 1);
    send_at(255, 0, $urandom() | 1);
    send_at(100, 225, 32'h0);
  endtask

  task automatic test_wide_mode();
    apply_setting(8'($urandom()), 1'b1, 1'b1, 10'd200, 10'd0);
    send_at(114, 225, $urandom() | 1);
    send_at(115, 225, $urandom() | 1);
    send_at(255, 105, $urandom() | 1);
    apply_setting(8'($urandom()), 1'b1, 1'b1, 10'd1023, 10'd1023);
    send_at(255, 255, $urandom() | 1);
  endtask

  task automatic test_random_settings();
    int      r;
    int      org[2];
    for (int phase = 0; phase < 10; phase++) begin
      foreach (org[k]) begin
        r = $urandom_range(0, 9);
        if (r == 0) org[k] = 0;
        else if (r == 1) org[k] = 1023;
        else if (r < 8) org[k] = $urandom_range(0, 300);
        else org[k] = $urandom_range(0, 1023);
      end
      r = $urandom_range(0, 3);
      apply_setting(r == 0 ? 8'd0 : r == 1 ? 8'd255 : 8'($urandom()),
                    phase % 4 != 0, phase % 3 == 1, 10'(org[0]), 10'(org[1]));
      gaps_on = phase != 6;
      stalls_on = phase != 6;
      for (int n = 0; n < 70; n++) begin
        if (n == 35 && phase % 3 == 0) wait_results_done();
        send_pixel(random_pixel());
      end
    end
    gaps_on = 1'b1;
    stalls_on = 1'b1;
  endtask

  task automatic test_back_to_back();
    apply_setting(8'($urandom()), 1'b1, 1'b0, 10'($urandom_range(0, 250)), 10'd0);
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    repeat (50) send_pixel(random_pixel());
    gaps_on = 1'b1;
    stalls_on = 1'b1;
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_register_access();
    test_field_extremes();
    test_logo_mask();
    test_wide_mode();
    test_random_settings();
    test_back_to_back();
    wait_results_done();
    $display("Sent %0d pixel transactions under %0d register settings; %0d were written.",
             sent_count, settings_count, written_count);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatches in total", mismatch_count);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
